// ----- rtl/core/motor_reply_frame_decoder_defines.svh -----
// Assertion macros for the motor reply frame decoder.
// Included by the top-level decoder file, which checks its own logic; no other dependencies.
`ifndef MOTOR_REPLY_FRAME_DECODER_DEFINES_SVH
`define MOTOR_REPLY_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MRFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MRFD_ASSERT_NOW(lbl, ante, cons, msg)
`define MRFD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/core/mrfd_pkg.sv -----
// Types, codes and constants shared by the motor reply frame decoder.
// No dependencies; every module of the decoder imports this package.
package mrfd_pkg;

  // Kind of a decoded reply frame, as reported on the result channel.
  typedef enum logic [2:0] {
    KIND_TORQUE  = 3'd0,
    KIND_ENCODER = 3'd1,
    KIND_STATE   = 3'd2,
    KIND_GAINS   = 3'd3,
    KIND_ANGLE   = 3'd4,
    KIND_UNKNOWN = 3'd5
  } mrfd_kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MOTOR_MODEL     = 3'd0,
    REG_REVERSE_DIR     = 3'd1,
    REG_CODE_TORQUE     = 3'd2,
    REG_CODE_ENCODER    = 3'd3,
    REG_CODE_ANGLE      = 3'd4,
    REG_CODE_STATE      = 3'd5,
    REG_CODE_GAIN_READ  = 3'd6,
    REG_CODE_GAIN_WRITE = 3'd7
  } mrfd_reg_e;

  // Motor models; the last code has no torque constant.
  typedef enum logic [1:0] {
    MODEL_LARGE        = 2'd0,
    MODEL_GEARED       = 2'd1,
    MODEL_HIGH_CURRENT = 2'd2,
    MODEL_NONE         = 2'd3
  } mrfd_model_e;

  typedef struct packed {
    mrfd_model_e motor_model;
    logic        reverse_dir;
    logic [7:0]  code_torque;
    logic [7:0]  code_encoder;
    logic [7:0]  code_angle;
    logic [7:0]  code_state;
    logic [7:0]  code_gain_read;
    logic [7:0]  code_gain_write;
  } mrfd_cfg_t;

  // One classified frame travelling from the front part to the back part.
  typedef struct packed {
    mrfd_kind_e         kind;
    logic [63:0]        frame;
    logic signed [26:0] torque;
  } mrfd_entry_t;

  // Reset values of the reply codes.
  localparam logic [7:0] CODE_TORQUE_RST     = 8'd161;
  localparam logic [7:0] CODE_ENCODER_RST    = 8'd144;
  localparam logic [7:0] CODE_ANGLE_RST      = 8'd146;
  localparam logic [7:0] CODE_STATE_RST      = 8'd154;
  localparam logic [7:0] CODE_GAIN_READ_RST  = 8'd48;
  localparam logic [7:0] CODE_GAIN_WRITE_RST = 8'd49;

  // Torque is |current| * K / 25 rounded, with K = 25 * whole + frac.
  // Rounding adds half the divisor before the floor division.
  localparam logic [21:0] ROUND_BIAS  = 22'd12;
  // ceil(2^25 / 25): exact floor division by 25 for dividends below 2^20.
  localparam logic [20:0] RECIP_25    = 21'd1342178;
  localparam int          RECIP_SHIFT = 25;

  // Saturation limits of the multi-turn sum.
  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  // Whole multiples of 25 in the torque constant of each model.
  function automatic logic [10:0] torque_whole(input mrfd_model_e model);
    logic [10:0] k;
    case (model)
      MODEL_LARGE:        k = 11'd168;
      MODEL_GEARED:       k = 11'd1520;
      MODEL_HIGH_CURRENT: k = 11'd1151;
      default:            k = 11'd0;
    endcase
    return k;
  endfunction

  // Remainder of the torque constant of each model after division by 25.
  function automatic logic [4:0] torque_frac(input mrfd_model_e model);
    logic [4:0] k;
    case (model)
      MODEL_LARGE:        k = 5'd24;
      MODEL_GEARED:       k = 5'd16;
      MODEL_HIGH_CURRENT: k = 5'd1;
      default:            k = 5'd0;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/motor_reply_frame_decoder.sv -----
// Motor reply frame decoder: decodes 8-byte motor reply frames into held values.
//
// Input channel: in_valid_i, in_stall_o and frame_data_i (byte 0 in bits 7..0).
// A transaction completes at a rising edge with in_valid_i high and in_stall_o low.
// Result channel: out_valid_o, out_stall_i and one port per result field; every
// frame gives exactly one result with its kind and all held values after it.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i; write only
// while no frame is in flight.
// Throughput is one frame per cycle while out_stall_i stays low: a three-stage
// front pipeline holds the torque multiply and the division by 25, the queue
// follows, and the back part updates the angle sum as it takes each frame.
// Reset clears all held values and the in-flight pipeline and loads the default
// reply codes; no clearing pass follows.
// When out_stall_i is high the result holds, the two-entry queue fills, then
// the front pipeline freezes and in_stall_o rises.
// Depends on mrfd_pkg, mrfd_front, mrfd_queue, mrfd_back and the defines header.
`include "motor_reply_frame_decoder_defines.svh"

module motor_reply_frame_decoder import mrfd_pkg::*; #(
  parameter int ENCODER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        frame_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         frame_kind_o,
  output logic [7:0]         temperature_o,
  output logic signed [15:0] current_raw_o,
  output logic signed [26:0] torque_value_o,
  output logic signed [15:0] speed_value_o,
  output logic [15:0]        encoder_position_o,
  output logic signed [47:0] angle_sum_o,
  output logic [15:0]        shaft_count_o,
  output logic [15:0]        shaft_offset_o,
  output logic [15:0]        supply_voltage_o,
  output logic [7:0]         error_flags_o,
  output logic [47:0]        pid_gains_o
);

  mrfd_cfg_t   cfg_q;
  logic        q_push, q_full, q_pop, q_empty;
  mrfd_entry_t q_in, q_head;
  mrfd_kind_e  kind;
  logic        pop_other;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_model     <= MODEL_LARGE;
      cfg_q.reverse_dir     <= 1'b0;
      cfg_q.code_torque     <= CODE_TORQUE_RST;
      cfg_q.code_encoder    <= CODE_ENCODER_RST;
      cfg_q.code_angle      <= CODE_ANGLE_RST;
      cfg_q.code_state      <= CODE_STATE_RST;
      cfg_q.code_gain_read  <= CODE_GAIN_READ_RST;
      cfg_q.code_gain_write <= CODE_GAIN_WRITE_RST;
    end else if (cfg_we_i) begin
      case (mrfd_reg_e'(cfg_index_i))
        REG_MOTOR_MODEL:     cfg_q.motor_model     <= mrfd_model_e'(cfg_data_i[1:0]);
        REG_REVERSE_DIR:     cfg_q.reverse_dir     <= cfg_data_i[0];
        REG_CODE_TORQUE:     cfg_q.code_torque     <= cfg_data_i;
        REG_CODE_ENCODER:    cfg_q.code_encoder    <= cfg_data_i;
        REG_CODE_ANGLE:      cfg_q.code_angle      <= cfg_data_i;
        REG_CODE_STATE:      cfg_q.code_state      <= cfg_data_i;
        REG_CODE_GAIN_READ:  cfg_q.code_gain_read  <= cfg_data_i;
        REG_CODE_GAIN_WRITE: cfg_q.code_gain_write <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front part: classification and torque pipeline.
  mrfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_data_i (frame_data_i),
    .push_o       (q_push),
    .push_entry_o (q_in),
    .q_full_i     (q_full)
  );

  // Queue that decouples the two parts.
  mrfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_o       (q_head),
    .empty_o      (q_empty)
  );

  // Back part: held values, angle unwrap and result register.
  mrfd_back #(
    .ENCODER_BITS (ENCODER_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_empty_i          (q_empty),
    .head_i             (q_head),
    .pop_o              (q_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_kind_o       (kind),
    .temperature_o      (temperature_o),
    .current_raw_o      (current_raw_o),
    .torque_value_o     (torque_value_o),
    .speed_value_o      (speed_value_o),
    .encoder_position_o (encoder_position_o),
    .angle_sum_o        (angle_sum_o),
    .shaft_count_o      (shaft_count_o),
    .shaft_offset_o     (shaft_offset_o),
    .supply_voltage_o   (supply_voltage_o),
    .error_flags_o      (error_flags_o),
    .pid_gains_o        (pid_gains_o)
  );

  assign frame_kind_o = kind;

  // A frame of any kind but torque leaves the angle sum alone.
  assign pop_other = q_pop && (q_head.kind != KIND_TORQUE);

  // Checks on the queue handshake and the angle sum.
  `MRFD_ASSERT_NOW(a_queue_no_overflow, q_push, !q_full, "queue pushed while full")
  `MRFD_ASSERT_NOW(a_queue_no_underflow, q_pop, !q_empty, "queue popped while empty")
  `MRFD_ASSERT_NOW(a_no_pop_when_stalled, out_valid_o && out_stall_i, !q_pop, "pop under stall")
  `MRFD_ASSERT_NEXT(a_sum_torque_only, pop_other, $stable(angle_sum_o), "sum moved on other kind")

endmodule

// ----- rtl/core/mrfd_front.sv -----
// Front part of the motor reply frame decoder: accepts frames, classifies
// them by byte 0 and computes the torque in a three-stage pipeline.
// Depends on mrfd_pkg.
module mrfd_front import mrfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mrfd_cfg_t   cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] frame_data_i,
  output logic        push_o,
  output mrfd_entry_t push_entry_o,
  input  logic        q_full_i
);

  logic        s1_v_q, s2_v_q, s3_v_q;
  logic        s1_v_d, s2_v_d, s3_v_d;
  logic        adv;
  mrfd_kind_e  kind_in;
  mrfd_kind_e  s1_kind_q, s2_kind_q, s3_kind_q;
  logic [63:0] s1_frame_q, s2_frame_q, s3_frame_q;

  logic signed [15:0] cur;
  logic [16:0] mag;
  logic [27:0] pa_full;
  logic [21:0] x_full;
  logic [25:0] s2_pa_q, s3_pa_q;
  logic [19:0] s2_x_q;
  logic        s2_neg_q, s3_neg_q;
  logic [40:0] y_full;
  logic [15:0] s3_q_q;
  logic [25:0] torque_mag;

  // The whole pipeline moves unless the last stage holds a frame the queue cannot take.
  assign adv        = !(s3_v_q && q_full_i);
  assign in_stall_o = !adv;
  assign push_o     = s3_v_q && !q_full_i;

  // Classify by byte 0; the first matching code wins.
  always_comb begin
    if (frame_data_i[7:0] == cfg_i.code_torque) begin
      kind_in = KIND_TORQUE;
    end else if (frame_data_i[7:0] == cfg_i.code_encoder) begin
      kind_in = KIND_ENCODER;
    end else if (frame_data_i[7:0] == cfg_i.code_angle) begin
      kind_in = KIND_ANGLE;
    end else if (frame_data_i[7:0] == cfg_i.code_state) begin
      kind_in = KIND_STATE;
    end else if ((frame_data_i[7:0] == cfg_i.code_gain_read) ||
                 (frame_data_i[7:0] == cfg_i.code_gain_write)) begin
      kind_in = KIND_GAINS;
    end else begin
      kind_in = KIND_UNKNOWN;
    end
  end

  // Stage two: magnitude of the current code times both parts of the constant.
  assign cur     = $signed(s1_frame_q[31:16]);
  assign mag     = cur[15] ? (~{cur[15], cur} + 17'd1) : {1'b0, cur};
  assign pa_full = {11'd0, mag} * {17'd0, torque_whole(cfg_i.motor_model)};
  assign x_full  = ({5'd0, mag} * {17'd0, torque_frac(cfg_i.motor_model)}) + ROUND_BIAS;

  // Stage three: divide the remainder part by 25 through its reciprocal.
  assign y_full = {21'd0, s2_x_q} * {20'd0, RECIP_25};

  // Push: add both parts and restore the sign.
  assign torque_mag = s3_pa_q + {10'd0, s3_q_q};

  always_comb begin
    push_entry_o.kind   = s3_kind_q;
    push_entry_o.frame  = s3_frame_q;
    push_entry_o.torque = s3_neg_q ? $signed(27'd0 - {1'b0, torque_mag})
                                   : $signed({1'b0, torque_mag});
  end

  // Stage valid flags.
  assign s1_v_d = adv ? in_valid_i : s1_v_q;
  assign s2_v_d = adv ? s1_v_q : s2_v_q;
  assign s3_v_d = adv ? s2_v_q : s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q  <= kind_in;
      s1_frame_q <= frame_data_i;
      s2_kind_q  <= s1_kind_q;
      s2_frame_q <= s1_frame_q;
      s2_pa_q    <= pa_full[25:0];
      s2_x_q     <= x_full[19:0];
      s2_neg_q   <= cur[15];
      s3_kind_q  <= s2_kind_q;
      s3_frame_q <= s2_frame_q;
      s3_pa_q    <= s2_pa_q;
      s3_q_q     <= y_full[40:RECIP_SHIFT];
      s3_neg_q   <= s2_neg_q;
    end
  end

endmodule

// ----- rtl/core/mrfd_queue.sv -----
// Two-entry queue between the front and the back part of the decoder.
// Depends on mrfd_pkg for the entry type.
module mrfd_queue import mrfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mrfd_entry_t push_entry_i,
  output logic        full_o,
  input  logic        pop_i,
  output mrfd_entry_t head_o,
  output logic        empty_o
);

  mrfd_entry_t entries_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entries_q[rd_ptr_q];

  // Occupancy follows the push and pop of each cycle.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/core/mrfd_back.sv -----
// Back part of the decoder: applies each classified frame to the held values,
// unwraps the encoder angle into the multi-turn sum and holds the result.
// Depends on mrfd_pkg.
module mrfd_back import mrfd_pkg::*; #(
  parameter int ENCODER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrfd_cfg_t          cfg_i,
  input  logic               q_empty_i,
  input  mrfd_entry_t        head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mrfd_kind_e         frame_kind_o,
  output logic [7:0]         temperature_o,
  output logic signed [15:0] current_raw_o,
  output logic signed [26:0] torque_value_o,
  output logic signed [15:0] speed_value_o,
  output logic [15:0]        encoder_position_o,
  output logic signed [47:0] angle_sum_o,
  output logic [15:0]        shaft_count_o,
  output logic [15:0]        shaft_offset_o,
  output logic [15:0]        supply_voltage_o,
  output logic [7:0]         error_flags_o,
  output logic [47:0]        pid_gains_o
);

  localparam int PW = (ENCODER_BITS > 16) ? ENCODER_BITS : 16;
  localparam int DW = ENCODER_BITS + 2;
  localparam logic signed [DW-1:0] TURN_C  = DW'(1) << ENCODER_BITS;
  localparam logic signed [DW-1:0] HALF_C  = DW'(1) << (ENCODER_BITS - 1);
  localparam logic signed [DW-1:0] NHALF_C = -HALF_C;

  logic               out_v_q, out_v_d;
  mrfd_kind_e         kind_q;
  logic [7:0]         temp_q;
  logic signed [15:0] cur_q;
  logic signed [26:0] torque_q;
  logic signed [15:0] speed_q;
  logic [15:0]        pos_q;
  logic signed [47:0] sum_q, sum_d;
  logic [15:0]        enc_raw_q;
  logic [15:0]        offset_q;
  logic [15:0]        volt_q;
  logic [7:0]         err_q;
  logic [47:0]        gains_q;

  logic [15:0]          enc;
  logic [PW-1:0]        enc_ext, last_ext;
  logic [ENCODER_BITS-1:0] now, last;
  logic signed [DW-1:0] d_raw, d_wrap, d_fin;
  logic signed [48:0]   sum_ext;

  // Take the next frame when the result register is free or being taken.
  assign pop_o   = !q_empty_i && (!out_v_q || !out_stall_i);
  assign out_v_d = pop_o || (out_v_q && out_stall_i);

  // Angle increment: position difference wrapped into half a turn.
  assign enc      = head_i.frame[63:48];
  assign enc_ext  = PW'(enc);
  assign last_ext = PW'(pos_q);
  assign now      = enc_ext[ENCODER_BITS-1:0];
  assign last     = last_ext[ENCODER_BITS-1:0];
  assign d_raw    = $signed(DW'(now)) - $signed(DW'(last));

  always_comb begin
    if (d_raw > HALF_C) begin
      d_wrap = d_raw - TURN_C;
    end else if (d_raw < NHALF_C) begin
      d_wrap = d_raw + TURN_C;
    end else begin
      d_wrap = d_raw;
    end
    // Starting from rest adds nothing.
    if ((last == '0) && (sum_q == '0)) begin
      d_wrap = '0;
    end
    d_fin = cfg_i.reverse_dir ? -d_wrap : d_wrap;
  end

  // Saturating accumulation of the multi-turn sum.
  assign sum_ext = $signed({sum_q[47], sum_q}) + $signed({{(49 - DW){d_fin[DW-1]}}, d_fin});

  always_comb begin
    if (sum_ext[48] != sum_ext[47]) begin
      sum_d = sum_ext[48] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_d = sum_ext[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      kind_q    <= KIND_UNKNOWN;
      temp_q    <= '0;
      cur_q     <= '0;
      torque_q  <= '0;
      speed_q   <= '0;
      pos_q     <= '0;
      sum_q     <= '0;
      enc_raw_q <= '0;
      offset_q  <= '0;
      volt_q    <= '0;
      err_q     <= '0;
      gains_q   <= '0;
    end else begin
      out_v_q <= out_v_d;
      if (pop_o) begin
        kind_q <= head_i.kind;
        case (head_i.kind)
          KIND_TORQUE: begin
            temp_q  <= head_i.frame[15:8];
            cur_q   <= $signed(head_i.frame[31:16]);
            speed_q <= $signed(head_i.frame[47:32]);
            pos_q   <= enc;
            sum_q   <= sum_d;
            if (cfg_i.motor_model != MODEL_NONE) begin
              torque_q <= head_i.torque;
            end
          end
          KIND_ENCODER: begin
            enc_raw_q <= head_i.frame[47:32];
            offset_q  <= head_i.frame[63:48];
          end
          KIND_STATE: begin
            temp_q <= head_i.frame[15:8];
            volt_q <= head_i.frame[31:16];
            err_q  <= head_i.frame[63:56];
          end
          KIND_GAINS: begin
            gains_q <= head_i.frame[63:16];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // The held values are the result payload.
  assign out_valid_o        = out_v_q;
  assign frame_kind_o       = kind_q;
  assign temperature_o      = temp_q;
  assign current_raw_o      = cur_q;
  assign torque_value_o     = torque_q;
  assign speed_value_o      = speed_q;
  assign encoder_position_o = pos_q;
  assign angle_sum_o        = sum_q;
  assign shaft_count_o      = enc_raw_q;
  assign shaft_offset_o     = offset_q;
  assign supply_voltage_o   = volt_q;
  assign error_flags_o      = err_q;
  assign pid_gains_o        = gains_q;

endmodule
